// File: src/stroke_box_smoother_unit_macros.svh
// Assertion macros for the stroke box smoother.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef STROKE_BOX_SMOOTHER_UNIT_MACROS_SVH
`define STROKE_BOX_SMOOTHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("stroke box smoother: assertion failed");

// Next-cycle implication, disabled during reset.
`define SBS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("stroke box smoother: assertion failed");

`endif

// File: src/sbs_pkg.sv
// Shared types, widths and the reciprocal table of the stroke box smoother.
// No dependencies; imported by stroke_box_smoother_unit.
`timescale 1ns / 1ps
package sbs_pkg;

  // Default sizes of the top level
  localparam int DEF_MAX_RADIUS  = 63;
  localparam int DEF_STORE_DEPTH = 128;

  // Field and datapath widths
  localparam int COORD_W = 24;
  localparam int PRES_W  = 16;
  localparam int RAD_W   = 6;
  localparam int CNT_W   = 8;
  localparam int SUM_W   = 31;
  localparam int RECIP_W = 25;
  localparam int FRAC_SH = 24;
  localparam int PROD_W  = SUM_W + RECIP_W + 1;
  localparam int Q_W     = PROD_W - FRAC_SH;
  localparam int TWO24   = 1 << FRAC_SH;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [PRES_W-1:0]  pres_t;
  typedef logic        [RAD_W-1:0]   rad_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  // Control that rides along the arithmetic pipeline
  typedef struct packed {
    logic pass;      // point leaves unchanged
    logic final_pt;  // closing point of the stroke
    rad_t r;         // radius used for this point
  } sbs_ctl_t;

  // Rounded reciprocal of the window length 2r+1, scaled by 2^24
  localparam logic [RECIP_W-1:0] RECIP_TAB [64] = '{
    25'((TWO24 +  0) /   1), 25'((TWO24 +  1) /   3), 25'((TWO24 +  2) /   5),
    25'((TWO24 +  3) /   7), 25'((TWO24 +  4) /   9), 25'((TWO24 +  5) /  11),
    25'((TWO24 +  6) /  13), 25'((TWO24 +  7) /  15), 25'((TWO24 +  8) /  17),
    25'((TWO24 +  9) /  19), 25'((TWO24 + 10) /  21), 25'((TWO24 + 11) /  23),
    25'((TWO24 + 12) /  25), 25'((TWO24 + 13) /  27), 25'((TWO24 + 14) /  29),
    25'((TWO24 + 15) /  31), 25'((TWO24 + 16) /  33), 25'((TWO24 + 17) /  35),
    25'((TWO24 + 18) /  37), 25'((TWO24 + 19) /  39), 25'((TWO24 + 20) /  41),
    25'((TWO24 + 21) /  43), 25'((TWO24 + 22) /  45), 25'((TWO24 + 23) /  47),
    25'((TWO24 + 24) /  49), 25'((TWO24 + 25) /  51), 25'((TWO24 + 26) /  53),
    25'((TWO24 + 27) /  55), 25'((TWO24 + 28) /  57), 25'((TWO24 + 29) /  59),
    25'((TWO24 + 30) /  61), 25'((TWO24 + 31) /  63), 25'((TWO24 + 32) /  65),
    25'((TWO24 + 33) /  67), 25'((TWO24 + 34) /  69), 25'((TWO24 + 35) /  71),
    25'((TWO24 + 36) /  73), 25'((TWO24 + 37) /  75), 25'((TWO24 + 38) /  77),
    25'((TWO24 + 39) /  79), 25'((TWO24 + 40) /  81), 25'((TWO24 + 41) /  83),
    25'((TWO24 + 42) /  85), 25'((TWO24 + 43) /  87), 25'((TWO24 + 44) /  89),
    25'((TWO24 + 45) /  91), 25'((TWO24 + 46) /  93), 25'((TWO24 + 47) /  95),
    25'((TWO24 + 48) /  97), 25'((TWO24 + 49) /  99), 25'((TWO24 + 50) / 101),
    25'((TWO24 + 51) / 103), 25'((TWO24 + 52) / 105), 25'((TWO24 + 53) / 107),
    25'((TWO24 + 54) / 109), 25'((TWO24 + 55) / 111), 25'((TWO24 + 56) / 113),
    25'((TWO24 + 57) / 115), 25'((TWO24 + 58) / 117), 25'((TWO24 + 59) / 119),
    25'((TWO24 + 60) / 121), 25'((TWO24 + 61) / 123), 25'((TWO24 + 62) / 125),
    25'((TWO24 + 63) / 127)
  };

endpackage

// File: src/stroke_box_smoother_unit.sv
// Top level of the stroke box smoother: point store, prefix-sum store,
// flush sequencer and the five-stage averaging pipeline.
// Depends on sbs_pkg and stroke_box_smoother_unit_macros.svh.
//
//   channel | handshake            | one beat carries
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_stall  | stroke point x, y, pressure, last
//   out     | out_valid / out_stall| smoothed x, y, pressure, last
//   cfg     | cfg_we               | radius (cfg_wdata), no read-back
//
// Sustained rate is one point per cycle when not stalled, set by the single write
// port of the point and prefix stores and the one-request-per-cycle issue slot.
// A last point at index p flushes min(p, R) + 1 results; in_stall stays high
// until its min(p, R) extra requests issue, longer while out_stall holds.
// Reset is synchronous; the stores are not cleared, no clearing pass.
// A result is registered at each pipeline stage; stages close up under out_stall.
`timescale 1ns / 1ps
`include "stroke_box_smoother_unit_macros.svh"
module stroke_box_smoother_unit #(
  parameter int MAX_RADIUS  = sbs_pkg::DEF_MAX_RADIUS,
  parameter int STORE_DEPTH = sbs_pkg::DEF_STORE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sbs_pkg::coord_t in_x,
  input  sbs_pkg::coord_t in_y,
  input  sbs_pkg::pres_t  in_pressure,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_stall,
  output sbs_pkg::coord_t out_x,
  output sbs_pkg::coord_t out_y,
  output sbs_pkg::pres_t  out_pressure,
  output logic            out_last,
  input  logic            cfg_we,
  input  sbs_pkg::rad_t   cfg_wdata
);
  import sbs_pkg::*;

  localparam int SLOT_W = $clog2(STORE_DEPTH);
  localparam int RLIM_I = (MAX_RADIUS < (STORE_DEPTH - 1) / 2) ? MAX_RADIUS
                                                              : (STORE_DEPTH - 1) / 2;
  localparam rad_t                    R_LIM     = RAD_W'(RLIM_I);
  localparam logic [SLOT_W:0]         DEPTH_X   = (SLOT_W + 1)'(STORE_DEPTH);
  localparam logic [SLOT_W-1:0]       LAST_SLOT = SLOT_W'(STORE_DEPTH - 1);
  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(2 ** (FRAC_SH - 1));
  localparam logic signed [Q_W-1:0]   Q_MAX     = Q_W'(COORD_MAX);
  localparam logic signed [Q_W-1:0]   Q_MIN     = Q_W'(COORD_MIN);
  localparam logic [CNT_W-1:0]        SEEN_SAT  = '1;

  // Slot that lies back_n points before base in the circular store
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] base,
                                                  input logic [SLOT_W:0] back_n);
    logic [SLOT_W:0] wide;
    if ({1'b0, base} >= back_n) wide = {1'b0, base} - back_n;
    else                        wide = {1'b0, base} + DEPTH_X - back_n;
    return wide[SLOT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- state
  rad_t               radius_r;
  logic [CNT_W-1:0]   seen_r;
  logic [SLOT_W-1:0]  wslot_r, bslot_r;
  coord_t             cur_x_r, cur_y_r, first_x_r, first_y_r;
  pres_t              cur_p_r;
  sum_t               scur_x_r, scur_y_r;
  logic               flush_r;
  rad_t               fl_d_r, fl_r_r;
  logic [CNT_W-1:0]   fl_p_r;

  // point store {pressure, y, x} and prefix-sum store {sum y, sum x}
  logic [2*COORD_W+PRES_W-1:0] pt_mem  [STORE_DEPTH];
  logic [2*SUM_W-1:0]          sum_mem [STORE_DEPTH];
  logic [2*COORD_W+PRES_W-1:0] pt_rd_r;
  logic [2*SUM_W-1:0]          sum_rd_r;

  // pipeline registers
  logic       v1_r, v2_r, v3_r, v4_r, out_valid_r;
  sbs_ctl_t   ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  rad_t       nlo1_r;
  logic [6:0] nhi1_r;
  logic       sub1_r, mecur1_r;
  coord_t     cx1_r, cy1_r, fx1_r, fy1_r;
  pres_t      cp1_r;
  sum_t       sx1_r, sy1_r;
  coord_t     mx2_r, my2_r, mx3_r, my3_r, mx4_r, my4_r;
  pres_t      mp2_r, mp3_r, mp4_r;
  sum_t       bx2_r, by2_r, lx2_r, ly2_r, hx2_r, hy2_r;
  sum_t       sumx3_r, sumy3_r;
  logic [RECIP_W-1:0] recip3_r;
  logic signed [PROD_W-1:0] prx4_r, pry4_r;
  coord_t     out_x_r, out_y_r;
  pres_t      out_p_r;
  logic       out_last_r;

  // ---------------------------------------------------------------- handshake
  logic en1, en2, en3, en4, en5, acc;

  assign en5      = !out_valid_r || !out_stall;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = flush_r || !en1;
  assign acc      = in_valid && !in_stall;

  // ---------------------------------------------------------------- issue
  rad_t             r_eff, d0;
  sum_t             sx_nxt, sy_nxt;
  logic             iss, is_last;
  rad_t             is_d, is_r;
  logic [CNT_W-1:0] is_p;
  logic [SLOT_W-1:0] is_base;
  coord_t           is_cx, is_cy, is_fx, is_fy;
  pres_t            is_cp;
  sum_t             is_sx, is_sy;

  assign r_eff  = (radius_r > R_LIM) ? R_LIM : radius_r;
  assign d0     = (seen_r < CNT_W'(r_eff)) ? seen_r[RAD_W-1:0] : r_eff;
  assign sx_nxt = ((seen_r == '0) ? sum_t'(0) : scur_x_r) + sum_t'(in_x);
  assign sy_nxt = ((seen_r == '0) ? sum_t'(0) : scur_y_r) + sum_t'(in_y);

  // requests come from the arriving point, or from the flush sequencer
  always_comb begin
    if (flush_r) begin
      iss     = en1;
      is_d    = fl_d_r;
      is_r    = fl_r_r;
      is_p    = fl_p_r;
      is_last = 1'b1;
      is_base = bslot_r;
      is_cx   = cur_x_r;
      is_cy   = cur_y_r;
      is_cp   = cur_p_r;
      is_fx   = first_x_r;
      is_fy   = first_y_r;
      is_sx   = scur_x_r;
      is_sy   = scur_y_r;
    end else begin
      iss     = acc && (in_last || seen_r >= CNT_W'(r_eff));
      is_d    = in_last ? d0 : r_eff;
      is_r    = r_eff;
      is_p    = seen_r;
      is_last = in_last;
      is_base = wslot_r;
      is_cx   = in_x;
      is_cy   = in_y;
      is_cp   = in_pressure;
      is_fx   = (seen_r == '0) ? in_x : first_x_r;
      is_fy   = (seen_r == '0) ? in_y : first_y_r;
      is_sx   = sx_nxt;
      is_sy   = sy_nxt;
    end
  end

  // Window of point d back: distances 0..min(d+r, p), r-d extra copies of
  // the newest point, and copies of the first point past the stroke start.
  logic [6:0]        hi;
  logic [CNT_W-1:0]  hi_ext;
  logic [6:0]        nhi;
  logic              sub_en, fin_pt, pass_pt;
  logic [SLOT_W-1:0] pt_addr, sum_addr;

  assign hi       = {1'b0, is_d} + {1'b0, is_r};
  assign hi_ext   = CNT_W'(hi);
  assign nhi      = (hi_ext > is_p) ? 7'(hi_ext - is_p) : 7'd0;
  assign sub_en   = hi_ext < is_p;
  assign fin_pt   = is_last && (is_d == '0);
  assign pass_pt  = (CNT_W'(is_d) == is_p) || fin_pt || (is_r == '0);
  assign pt_addr  = slot_back(is_base, (SLOT_W + 1)'(is_d));
  assign sum_addr = slot_back(is_base, (SLOT_W + 1)'(hi_ext + 8'd1));

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= rad_t'(1);
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- stroke control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      wslot_r <= '0;
      flush_r <= 1'b0;
    end else if (flush_r) begin
      if (en1) begin
        if (fl_d_r == '0) flush_r <= 1'b0;
      end
    end else if (acc) begin
      if (in_last) begin
        seen_r  <= '0;
        wslot_r <= '0;
        flush_r <= (d0 != '0);
      end else begin
        if (seen_r != SEEN_SAT) seen_r <= seen_r + CNT_W'(1);
        wslot_r <= (wslot_r == LAST_SLOT) ? '0 : wslot_r + SLOT_W'(1);
      end
    end
  end

  // newest point, first point, running prefix and flush step
  always_ff @(posedge clk) begin
    if (flush_r) begin
      if (en1) fl_d_r <= fl_d_r - RAD_W'(1);
    end else if (acc) begin
      bslot_r  <= wslot_r;
      cur_x_r  <= in_x;
      cur_y_r  <= in_y;
      cur_p_r  <= in_pressure;
      scur_x_r <= sx_nxt;
      scur_y_r <= sy_nxt;
      if (seen_r == '0) begin
        first_x_r <= in_x;
        first_y_r <= in_y;
      end
      fl_d_r <= d0 - RAD_W'(1);
      fl_r_r <= r_eff;
      fl_p_r <= seen_r;
    end
  end

  // ---------------------------------------------------------------- stores
  always_ff @(posedge clk) begin
    if (acc) begin
      pt_mem[wslot_r]  <= {in_pressure, in_y, in_x};
      sum_mem[wslot_r] <= {sy_nxt, sx_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pt_rd_r  <= pt_mem[pt_addr];
      sum_rd_r <= sum_mem[sum_addr];
    end
  end

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= iss;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  // stage 1: request capture
  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1_r   <= '{pass: pass_pt, final_pt: fin_pt, r: is_r};
      nlo1_r   <= is_r - is_d;
      nhi1_r   <= nhi;
      sub1_r   <= sub_en;
      mecur1_r <= (is_d == '0);
      cx1_r    <= is_cx;
      cy1_r    <= is_cy;
      cp1_r    <= is_cp;
      fx1_r    <= is_fx;
      fy1_r    <= is_fy;
      sx1_r    <= is_sx;
      sy1_r    <= is_sy;
    end
  end

  // stage 2: centre point, range sum from prefixes, clamp copies
  sum_t bx_nxt, by_nxt, lx_nxt, ly_nxt, hx_nxt, hy_nxt;

  assign bx_nxt = sx1_r - (sub1_r ? sum_t'(sum_rd_r[SUM_W-1:0]) : sum_t'(0));
  assign by_nxt = sy1_r - (sub1_r ? sum_t'(sum_rd_r[2*SUM_W-1:SUM_W]) : sum_t'(0));
  assign lx_nxt = sum_t'(cx1_r) * sum_t'($signed({1'b0, nlo1_r}));
  assign ly_nxt = sum_t'(cy1_r) * sum_t'($signed({1'b0, nlo1_r}));
  assign hx_nxt = sum_t'(fx1_r) * sum_t'($signed({1'b0, nhi1_r}));
  assign hy_nxt = sum_t'(fy1_r) * sum_t'($signed({1'b0, nhi1_r}));

  always_ff @(posedge clk) begin
    if (en2) begin
      ctl2_r <= ctl1_r;
      mx2_r  <= mecur1_r ? cx1_r : coord_t'(pt_rd_r[COORD_W-1:0]);
      my2_r  <= mecur1_r ? cy1_r : coord_t'(pt_rd_r[2*COORD_W-1:COORD_W]);
      mp2_r  <= mecur1_r ? cp1_r : pres_t'(pt_rd_r[2*COORD_W+PRES_W-1:2*COORD_W]);
      bx2_r  <= bx_nxt;
      by2_r  <= by_nxt;
      lx2_r  <= lx_nxt;
      ly2_r  <= ly_nxt;
      hx2_r  <= hx_nxt;
      hy2_r  <= hy_nxt;
    end
  end

  // stage 3: window sum and reciprocal lookup
  always_ff @(posedge clk) begin
    if (en3) begin
      ctl3_r   <= ctl2_r;
      mx3_r    <= mx2_r;
      my3_r    <= my2_r;
      mp3_r    <= mp2_r;
      sumx3_r  <= bx2_r + lx2_r + hx2_r;
      sumy3_r  <= by2_r + ly2_r + hy2_r;
      recip3_r <= RECIP_TAB[ctl2_r.r];
    end
  end

  // stage 4: scale by the reciprocal
  logic signed [PROD_W-1:0] prx_nxt, pry_nxt;

  assign prx_nxt = PROD_W'(sumx3_r) * PROD_W'($signed({1'b0, recip3_r}));
  assign pry_nxt = PROD_W'(sumy3_r) * PROD_W'($signed({1'b0, recip3_r}));

  always_ff @(posedge clk) begin
    if (en4) begin
      ctl4_r <= ctl3_r;
      mx4_r  <= mx3_r;
      my4_r  <= my3_r;
      mp4_r  <= mp3_r;
      prx4_r <= prx_nxt;
      pry4_r <= pry_nxt;
    end
  end

  // stage 5: round half up, saturate, pick smoothed or unchanged point
  logic signed [PROD_W-1:0] rx, ry;
  logic signed [Q_W-1:0]    qx, qy;
  coord_t                   satx, saty;

  assign rx   = prx4_r + ROUND_ADD;
  assign ry   = pry4_r + ROUND_ADD;
  assign qx   = rx[PROD_W-1:FRAC_SH];
  assign qy   = ry[PROD_W-1:FRAC_SH];
  assign satx = (qx > Q_MAX) ? COORD_MAX : (qx < Q_MIN) ? COORD_MIN : coord_t'(qx);
  assign saty = (qy > Q_MAX) ? COORD_MAX : (qy < Q_MIN) ? COORD_MIN : coord_t'(qy);

  always_ff @(posedge clk) begin
    if (en5) begin
      out_x_r    <= ctl4_r.pass ? mx4_r : satx;
      out_y_r    <= ctl4_r.pass ? my4_r : saty;
      out_p_r    <= mp4_r;
      out_last_r <= ctl4_r.final_pt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_pressure = out_p_r;
  assign out_last     = out_last_r;

  // ---------------------------------------------------------------- checks
  `SBS_ASSERT_IMP(a_flush_fresh, clk, rst_n, flush_r, (seen_r == '0) && (wslot_r == '0))
  `SBS_ASSERT_IMP(a_flush_bound, clk, rst_n, flush_r, fl_d_r < fl_r_r)
  `SBS_ASSERT_NXT(a_issue_lands, clk, rst_n, iss, v1_r)

endmodule

// File: tb/tb_top.sv
// Self-checking bench for stroke_box_smoother_unit: smoothed-stroke predictor,
// result scoreboard and beat drivers. Depends on sbs_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_top;
  import sbs_pkg::*;

  localparam int STORE_SLOTS = DEF_STORE_DEPTH;
  localparam int RAD_CAP     = (DEF_MAX_RADIUS < (DEF_STORE_DEPTH - 1) / 2) ?
                               DEF_MAX_RADIUS : (DEF_STORE_DEPTH - 1) / 2;
  localparam int QUIET_LIMIT  = 3000;
  localparam int RANDOM_BEATS = 96;
  localparam int LONG_STROKE  = 140;

  typedef struct {
    coord_t x;
    coord_t y;
    pres_t  pressure;
    logic   last;
  } stroke_pt_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Predicts smoothed points and holds them until the unit emits them
  class stroke_scoreboard;
    stroke_pt_t history [STORE_SLOTS];
    int unsigned seen_cnt;
    int unsigned slot;
    int unsigned radius;
    stroke_pt_t  due_q [$];
    int          errors;

    function new();
      foreach (history[i]) history[i] = '{0, 0, 0, 1'b0};
      seen_cnt = 0;
      slot     = 0;
      radius   = 1;
      errors   = 0;
    endfunction

    // Point that arrived k beats before the newest one
    function stroke_pt_t recall(int unsigned k);
      return history[(slot + STORE_SLOTS - (k % STORE_SLOTS)) % STORE_SLOTS];
    endfunction

    function coord_t window_mean(longint total, int m);
      longint recip;
      longint v;
      longint q;
      recip = ((longint'(1) << FRAC_SH) + m / 2) / m;
      v = total * recip + (longint'(1) << (FRAC_SH - 1));
      q = v >>> FRAC_SH;
      if (q > longint'(COORD_MAX)) q = longint'(COORD_MAX);
      if (q < longint'(COORD_MIN)) q = longint'(COORD_MIN);
      return coord_t'(q);
    endfunction

    // Output for the point d beats back; p is the newest index, r the radius
    function stroke_pt_t smooth_point(int d, int p, int r, bit closing);
      stroke_pt_t res;
      stroke_pt_t pt;
      longint sx;
      longint sy;
      int k;
      int t;
      res = recall(d);
      res.last = closing && d == 0;
      if (!(d == p || res.last || r == 0)) begin
        sx = 0;
        sy = 0;
        for (t = -r; t <= r; t++) begin
          k = d - t;
          if (k < 0) k = 0;
          if (k > p) k = p;
          pt = recall(k);
          sx += longint'(pt.x);
          sy += longint'(pt.y);
        end
        res.x = window_mean(sx, 2 * r + 1);
        res.y = window_mean(sy, 2 * r + 1);
      end
      return res;
    endfunction

    // Accepted input beat: store it and queue what it releases
    function void note_point(stroke_pt_t pt);
      int r;
      int p;
      int d;
      r = (radius < RAD_CAP) ? radius : RAD_CAP;
      p = seen_cnt;
      history[slot] = pt;
      if (pt.last) begin
        d = (p < r) ? p : r;
        // flush every pending point, oldest first
        while (d >= 0) begin
          due_q.insert(due_q.size(), smooth_point(d, p, r, 1'b1));
          d--;
        end
        seen_cnt = 0;
        slot     = 0;
      end else begin
        if (p >= r) due_q.insert(due_q.size(), smooth_point(r, p, r, 1'b0));
        if (seen_cnt < 255) seen_cnt++;
        slot = (slot + 1) % STORE_SLOTS;
      end
    endfunction

    function void check_result(stroke_pt_t got);
      stroke_pt_t want;
      if (due_q.size() == 0) begin
        $error("result beat with nothing expected: x %0d y %0d", got.x, got.y);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.x !== want.x) begin
        $error("out_x: expected %0d, got %0d", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("out_y: expected %0d, got %0d", want.y, got.y);
        errors++;
      end
      if (got.pressure !== want.pressure) begin
        $error("out_pressure: expected %0d, got %0d", want.pressure, got.pressure);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n       = 1'b0;
  logic   in_valid    = 1'b0;
  logic   in_stall;
  coord_t in_x        = '0;
  coord_t in_y        = '0;
  pres_t  in_pressure = '0;
  logic   in_last     = 1'b0;
  logic   out_valid;
  logic   out_stall   = 1'b0;
  coord_t out_x;
  coord_t out_y;
  pres_t  out_pressure;
  logic   out_last;
  logic   cfg_we      = 1'b0;
  rad_t   cfg_wdata   = '0;

  stroke_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  stroke_box_smoother_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_pressure  (in_pressure),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_pressure (out_pressure),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result beats go to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_x, out_y, out_pressure, out_last});
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat; valid stays up afterwards until the next call or a drain
  task automatic send_point(input coord_t x, input coord_t y, input pres_t pres,
                            input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_x        <= x;
    in_y        <= y;
    in_pressure <= pres;
    in_last     <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_point('{x, y, pres, last});
  endtask

  // Sender pauses until every expected point is back and the unit settles
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_radius(input int r);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= rad_t'(r);
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.radius = r;
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 85;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 85;
      end
      default: begin
        send_idle_pct  = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return coord_t'(int'($urandom_range(4096)) - 2048);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic pres_t rand_pressure();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return pres_t'($urandom());
    endcase
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(7))
      0: return 0;
      1: return 63;
      2, 3: return 1;
      4, 5: return $urandom_range(2, 6);
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  initial begin
    int sent;
    int len;
    int i;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single and two-point strokes at the reset radius pass unchanged
    send_point(COORD_MAX, COORD_MIN, 16'hFFFF, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 16'h0000, 1'b0);
    send_point(24'sd0, -24'sd1, 16'h8001, 1'b1);
    // three points, the middle one averaged
    send_point(24'sh123456, -24'sd1000, 16'h5A5A, 1'b0);
    send_point(-24'sd77, 24'sh3C3C3C, 16'hA5A5, 1'b0);
    send_point(24'sd5, 24'sd6, 16'h0F0F, 1'b1);

    // Window length 25 has a reciprocal rounded up: full-scale mean saturates
    set_radius(12);
    repeat (2) send_point(COORD_MAX, COORD_MIN, 16'h1234, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 16'h4321, 1'b1);

    // Radius zero passes everything through
    set_radius(0);
    send_point(24'sd100, 24'sd200, 16'd1, 1'b0);
    send_point(-24'sd300, 24'sd400, 16'd2, 1'b0);
    send_point(24'sd500, -24'sd600, 16'd3, 1'b1);

    // Radius changed in the middle of a stroke
    set_radius(2);
    for (i = 0; i < 5; i++) send_point(rand_coord(), rand_coord(), rand_pressure(), 1'b0);
    set_radius(1);
    for (i = 0; i < 3; i++) send_point(rand_coord(), rand_coord(), rand_pressure(), i == 2);

    // Largest radius on a stroke shorter than the window
    set_radius(63);
    for (i = 0; i < 4; i++) send_point(rand_coord(), rand_coord(), rand_pressure(), i == 3);

    // Long stroke at full radius: store wraps, a 64-point flush; the receiver
    // holds off early so the unit backs up into the input
    drain_results();
    set_idle_mode(IDLE_NONE);
    hold_left = 200;
    for (i = 0; i < LONG_STROKE; i++)
      send_point(rand_coord(), rand_coord(), rand_pressure(), i == LONG_STROKE - 1);

    // Random strokes over the idling phases
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      if ($urandom_range(2) == 0) set_radius(pick_radius());
      len = ($urandom_range(4) == 0) ? $urandom_range(13, 90) : $urandom_range(1, 12);
      if (len > RANDOM_BEATS - sent) len = RANDOM_BEATS - sent;
      for (i = 0; i < len; i++) begin
        set_idle_mode(idle_mode_t'((sent * 4) / RANDOM_BEATS));
        send_point(rand_coord(), rand_coord(), rand_pressure(), i == len - 1);
        sent++;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/sbs_pkg.sv
src/stroke_box_smoother_unit.sv
tb/tb_top.sv
